// ===== design/acsc_pkg.sv =====
`timescale 1ns / 1ps

// Shared types and constants of the escape-stripping capture block.
package acsc_pkg;

    // Default sizing, handed down from the top level.
    localparam int MAX_SEQ_DEF     = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register port geometry.
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int LIMIT_W   = 12;
    localparam int COUNT_W   = 33;
    localparam int MIB_SHIFT = 20;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_CAPTURE_ON   = 2'd0;
    localparam logic [1:0] REG_STRIP_ENABLE = 2'd1;
    localparam logic [1:0] REG_LIMIT_MIB    = 2'd2;

    // Register reset values.
    localparam logic               CAPTURE_RESET = 1'b0;
    localparam logic               STRIP_RESET   = 1'b1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 12'd100;

    // Characters the parser looks for.
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_QUEST    = 8'h3F;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;
    localparam logic [7:0] CH_UPPER_LO = 8'h41;
    localparam logic [7:0] CH_UPPER_HI = 8'h5A;
    localparam logic [7:0] CH_LOWER_LO = 8'h61;
    localparam logic [7:0] CH_LOWER_HI = 8'h7A;

    // Result kinds.
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Byte classes found by the front end.
    typedef enum logic [2:0] {
        CLS_OTHER   = 3'd0,
        CLS_ESC     = 3'd1,
        CLS_BRACKET = 3'd2,
        CLS_LETTER  = 3'd3,
        CLS_PARAM   = 3'd4
    } byte_cls_t;

    // Input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } acsc_in_t;

    // Result word.
    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic       refused;
        logic       last_of_run;
    } acsc_out_t;

    // Classified word held in the queue.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
        byte_cls_t  cls;
    } acsc_cmd_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic               capture_on;
        logic               strip_enable;
        logic [LIMIT_W-1:0] limit_mib;
        logic               count_clear;
    } acsc_cfg_t;

endpackage

// ===== design/ansi_csi_strip_capture.sv =====
`timescale 1ns / 1ps
// Path of a word: front-end stage register, queue, back-end sequencer, output register.
// Throughput: one word per cycle while output is not stalled; the back-end sequencer also
// holds the queue while it flushes held bytes, sends the status word at a chunk end, or handles
// a word that waits behind a flush. The held-byte store has at most MAX_SEQ-1 entries.
// Reset: aresetn is synchronous and active low; it clears control state and restores the
// register defaults (capture off, stripping on, limit 100 MiB); the held bytes are not cleared.
module ansi_csi_strip_capture import acsc_pkg::*; #(
    parameter int MAX_SEQ     = MAX_SEQ_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  acsc_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output acsc_out_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic               capture_on_reg, capture_on_next;
    logic               strip_enable_reg, strip_enable_next;
    logic [LIMIT_W-1:0] limit_mib_reg, limit_mib_next;
    logic               reg_wr;
    logic [1:0]         reg_idx;
    acsc_cfg_t          cfg;
    logic               fq_valid, fq_ready;
    acsc_cmd_t          fq_cmd;
    logic               qb_valid, qb_pop;
    acsc_cmd_t          qb_cmd;

    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Register write decode.
    always_comb begin
        capture_on_next   = capture_on_reg;
        strip_enable_next = strip_enable_reg;
        limit_mib_next    = limit_mib_reg;
        if (reg_wr) begin
            unique case (reg_idx)
                REG_CAPTURE_ON:   capture_on_next   = pwdata[0];
                REG_STRIP_ENABLE: strip_enable_next = pwdata[0];
                REG_LIMIT_MIB:    limit_mib_next    = pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read decode.
    always_comb begin
        unique case (reg_idx)
            REG_CAPTURE_ON:   prdata = DATA_W'(capture_on_reg);
            REG_STRIP_ENABLE: prdata = DATA_W'(strip_enable_reg);
            REG_LIMIT_MIB:    prdata = DATA_W'(limit_mib_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_on_reg   <= CAPTURE_RESET;
            strip_enable_reg <= STRIP_RESET;
            limit_mib_reg    <= LIMIT_RESET;
        end else begin
            capture_on_reg   <= capture_on_next;
            strip_enable_reg <= strip_enable_next;
            limit_mib_reg    <= limit_mib_next;
        end
    end

    // Turning capture on also restarts the byte count.
    assign cfg = '{capture_on: capture_on_reg, strip_enable: strip_enable_reg,
                   limit_mib: limit_mib_reg,
                   count_clear: reg_wr && reg_idx == REG_CAPTURE_ON && pwdata[0]};

    acsc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_cmd   (fq_cmd)
    );

    acsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_pop   (qb_pop),
        .out_cmd   (qb_cmd)
    );

    acsc_back #(
        .MAX_SEQ (MAX_SEQ)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (qb_valid),
        .q_cmd   (qb_cmd),
        .q_pop   (qb_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== design/acsc_front.sv =====
`timescale 1ns / 1ps

// Input stage: takes one word per cycle while the queue has room, and tags it with its byte class.
module acsc_front import acsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  acsc_in_t  s_data,
    output logic      q_valid,
    input  logic      q_ready,
    output acsc_cmd_t q_cmd
);

    logic      valid_reg;
    acsc_cmd_t cmd_reg;
    logic      push;

    // Decode a byte into the classes the CSI parser needs.
    function automatic byte_cls_t classify(input logic [7:0] c);
        byte_cls_t r;
        r = CLS_OTHER;
        if (c == CH_ESC) begin
            r = CLS_ESC;
        end else if (c == CH_LBRACKET) begin
            r = CLS_BRACKET;
        end else if ((c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
                     (c >= CH_LOWER_LO && c <= CH_LOWER_HI)) begin
            r = CLS_LETTER;
        end else if ((c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) || c == CH_SEMI ||
                     c == CH_QUEST || c == CH_EQUAL) begin
            r = CLS_PARAM;
        end
        return r;
    endfunction

    assign push    = valid_reg && q_ready;
    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_cmd   = cmd_reg;

    // Stage register; refills in the cycle it hands its word on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (push) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= '{data_byte: s_data.data_byte, chunk_end: s_data.chunk_end,
                         cls: classify(s_data.data_byte)};
        end
    end

endmodule

// ===== design/acsc_queue.sv =====
`timescale 1ns / 1ps

// Short first-in first-out queue between the front and back ends.
module acsc_queue import acsc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  acsc_cmd_t in_cmd,
    output logic      out_valid,
    input  logic      out_pop,
    output acsc_cmd_t out_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);

    acsc_cmd_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push, do_pop;

    assign in_ready  = level_reg != LVL_FULL;
    assign out_valid = level_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_pop && out_valid;

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            level_next = level_reg + LVL_W'(1);
        end else if (do_pop && !do_push) begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== design/acsc_back.sv =====
`timescale 1ns / 1ps

// Back end: chunk bookkeeping, CSI parser, held-byte store, byte counter
// and the output register. One result leaves per cycle at most.
module acsc_back import acsc_pkg::*; #(
    parameter int MAX_SEQ = MAX_SEQ_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  acsc_cfg_t cfg,
    input  logic      q_valid,
    input  acsc_cmd_t q_cmd,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output acsc_out_t m_data
);

    localparam int HOLD_DEPTH = MAX_SEQ - 1;
    localparam int IDX_W      = $clog2(HOLD_DEPTH);
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(HOLD_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_EMIT    = 3'd1,
        ACT_START   = 3'd2,
        ACT_APPEND  = 3'd3,
        ACT_DISCARD = 3'd4
    } act_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FLUSH1 = 5'b00010,
        S_ACT    = 5'b00100,
        S_FLUSH2 = 5'b01000,
        S_STATUS = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic               in_chunk_reg, in_chunk_next;
    logic               refused_reg, refused_next;
    logic [COUNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [7:0]         c_reg, c_next;
    logic               end_reg, end_next;
    act_t               act_reg, act_next;
    logic [7:0]         held_reg [HOLD_DEPTH];
    logic               m_valid_reg, m_valid_next;
    acsc_out_t          m_data_reg, m_data_next;

    logic               adv;
    logic               over;
    logic               start_refused;
    logic               eff_refused;
    phase_t             eff_phase;
    logic [CNT_W-1:0]   eff_cnt;
    logic               pre_flush;
    act_t               act;
    act_t               text_act;
    logic               need_flush1;
    logic [7:0]         held_rd;
    logic               last_ptr;
    logic               emit;
    acsc_out_t          emit_data;
    logic               hold_we;
    logic [IDX_W-1:0]   hold_idx;
    logic [7:0]         hold_data;

    assign adv     = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign held_rd = held_reg[ptr_reg];
    assign last_ptr = CNT_W'(ptr_reg) == (cnt_reg - CNT_W'(1));

    // Refusal test made when a chunk starts.
    assign over = (cfg.limit_mib != '0) &&
                  (byte_cnt_reg > COUNT_W'({cfg.limit_mib, {MIB_SHIFT{1'b0}}}));
    assign start_refused = !cfg.capture_on || over;

    // A new chunk begins from plain text with nothing held.
    assign eff_refused = in_chunk_reg ? refused_reg : start_refused;
    assign eff_phase   = in_chunk_reg ? phase_reg : PH_TEXT;
    assign eff_cnt     = in_chunk_reg ? cnt_reg : '0;

    // Parser decision for the word at the head of the queue.
    always_comb begin
        text_act  = (q_cmd.cls == CLS_ESC) ? ACT_START : ACT_EMIT;
        pre_flush = 1'b0;
        act       = ACT_NONE;
        if (!eff_refused) begin
            if (!cfg.strip_enable) begin
                pre_flush = 1'b1;
                act       = ACT_EMIT;
            end else begin
                case (eff_phase)
                    PH_ESC: begin
                        if (q_cmd.cls == CLS_BRACKET) begin
                            act = ACT_APPEND;
                        end else begin
                            pre_flush = 1'b1;
                            act       = text_act;
                        end
                    end
                    PH_CSI: begin
                        if (q_cmd.cls == CLS_LETTER) begin
                            act = ACT_DISCARD;
                        end else if (q_cmd.cls == CLS_PARAM) begin
                            if (eff_cnt < CNT_FULL) begin
                                act = ACT_APPEND;
                            end else begin
                                pre_flush = 1'b1;
                                act       = ACT_EMIT;
                            end
                        end else begin
                            pre_flush = 1'b1;
                            act       = text_act;
                        end
                    end
                    default: begin
                        act = text_act;
                    end
                endcase
            end
        end
    end

    assign need_flush1 = pre_flush && (eff_cnt != '0);

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        in_chunk_next = in_chunk_reg;
        refused_next  = refused_reg;
        c_next        = c_reg;
        end_next      = end_reg;
        act_next      = act_reg;
        q_pop         = 1'b0;
        emit          = 1'b0;
        emit_data     = '{kind: KIND_BYTE, out_byte: 8'd0, refused: 1'b0, last_of_run: 1'b0};
        hold_we       = 1'b0;
        hold_idx      = '0;
        hold_data     = q_cmd.data_byte;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    if (need_flush1) begin
                        // Held bytes go out first; keep the word for later.
                        q_pop         = 1'b1;
                        in_chunk_next = 1'b1;
                        refused_next  = eff_refused;
                        c_next        = q_cmd.data_byte;
                        end_next      = q_cmd.chunk_end;
                        act_next      = act;
                        ptr_next      = '0;
                        state_next    = S_FLUSH1;
                    end else if (act != ACT_EMIT || adv) begin
                        q_pop         = 1'b1;
                        in_chunk_next = 1'b1;
                        refused_next  = eff_refused;
                        case (act)
                            ACT_EMIT: begin
                                emit       = 1'b1;
                                emit_data  = '{kind: KIND_BYTE, out_byte: q_cmd.data_byte,
                                              refused: 1'b0, last_of_run: !q_cmd.chunk_end};
                                cnt_next   = '0;
                                phase_next = PH_TEXT;
                            end
                            ACT_START: begin
                                hold_we    = 1'b1;
                                hold_idx   = '0;
                                cnt_next   = CNT_W'(1);
                                phase_next = PH_ESC;
                            end
                            ACT_APPEND: begin
                                hold_we    = 1'b1;
                                hold_idx   = eff_cnt[IDX_W-1:0];
                                cnt_next   = eff_cnt + CNT_W'(1);
                                phase_next = PH_CSI;
                            end
                            ACT_DISCARD: begin
                                cnt_next   = '0;
                                phase_next = PH_TEXT;
                            end
                            default: begin
                                cnt_next   = eff_cnt;
                                phase_next = eff_phase;
                            end
                        endcase
                        if (q_cmd.chunk_end) begin
                            ptr_next   = '0;
                            state_next = (cnt_next != '0) ? S_FLUSH2 : S_STATUS;
                        end
                    end
                end
            end
            S_FLUSH1: begin
                if (adv) begin
                    emit      = 1'b1;
                    emit_data = '{kind: KIND_BYTE, out_byte: held_rd, refused: 1'b0,
                                  last_of_run: last_ptr && act_reg != ACT_EMIT && !end_reg};
                    ptr_next  = ptr_reg + IDX_W'(1);
                    if (last_ptr) begin
                        cnt_next   = '0;
                        phase_next = PH_TEXT;
                        state_next = S_ACT;
                    end
                end
            end
            S_ACT: begin
                // After a flush the word is either emitted or opens a new escape.
                if (act_reg == ACT_EMIT) begin
                    if (adv) begin
                        emit       = 1'b1;
                        emit_data  = '{kind: KIND_BYTE, out_byte: c_reg, refused: 1'b0,
                                      last_of_run: !end_reg};
                        cnt_next   = '0;
                        phase_next = PH_TEXT;
                        state_next = end_reg ? S_STATUS : S_IDLE;
                    end
                end else begin
                    hold_we    = 1'b1;
                    hold_idx   = '0;
                    hold_data  = c_reg;
                    cnt_next   = CNT_W'(1);
                    phase_next = PH_ESC;
                    ptr_next   = '0;
                    state_next = end_reg ? S_FLUSH2 : S_IDLE;
                end
            end
            S_FLUSH2: begin
                if (adv) begin
                    emit      = 1'b1;
                    emit_data = '{kind: KIND_BYTE, out_byte: held_rd, refused: 1'b0,
                                  last_of_run: 1'b0};
                    ptr_next  = ptr_reg + IDX_W'(1);
                    if (last_ptr) begin
                        cnt_next   = '0;
                        phase_next = PH_TEXT;
                        state_next = S_STATUS;
                    end
                end
            end
            S_STATUS: begin
                if (adv) begin
                    emit          = 1'b1;
                    emit_data     = '{kind: KIND_STATUS, out_byte: 8'd0, refused: refused_reg,
                                      last_of_run: 1'b1};
                    in_chunk_next = 1'b0;
                    refused_next  = 1'b0;
                    cnt_next      = '0;
                    phase_next    = PH_TEXT;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register and saturating byte counter.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        byte_cnt_next = byte_cnt_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg.count_clear) begin
            byte_cnt_next = '0;
        end else if (emit && emit_data.kind == KIND_BYTE && byte_cnt_reg != COUNT_SAT) begin
            byte_cnt_next = byte_cnt_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_TEXT;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            in_chunk_reg <= 1'b0;
            refused_reg  <= 1'b0;
            byte_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            ptr_reg      <= ptr_next;
            in_chunk_reg <= in_chunk_next;
            refused_reg  <= refused_next;
            byte_cnt_reg <= byte_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers and the held-byte store.
    always_ff @(posedge aclk) begin
        c_reg      <= c_next;
        end_reg    <= end_next;
        act_reg    <= act_next;
        m_data_reg <= m_data_next;
        if (hold_we) begin
            held_reg[hold_idx] <= hold_data;
        end
    end

endmodule

// ===== design/acsc_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the result channel.
module acsc_checker import acsc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input acsc_out_t m_data
);

    // A stalled result word stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // A status word always closes the run of results of its input word.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_STATUS |-> m_data.last_of_run && m_data.out_byte == 8'd0)
        else $error("status word malformed");

    // A captured byte never carries the refusal flag.
    a_byte_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_BYTE |-> !m_data.refused)
        else $error("byte word flagged as refused");

    // Nothing is offered in the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind ansi_csi_strip_capture acsc_checker u_acsc_checker (.*);

// ===== dv/tb_ansi_csi_strip_capture.sv =====
`timescale 1ns / 1ps

module tb_ansi_csi_strip_capture;
    import acsc_pkg::*;

    localparam int SEQ_LIMIT     = MAX_SEQ_DEF;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD_OFF = 400;
    localparam int NUM_PHASES    = 6;

    typedef enum logic [1:0] {
        SCAN_TEXT,
        SCAN_ESC,
        SCAN_CSI
    } scan_phase_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    acsc_in_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    acsc_out_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ansi_csi_strip_capture dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 aclk = ~aclk;

    // Register copies and parser state of the capture model.
    logic               cfg_capture   = CAPTURE_RESET;
    logic               cfg_strip     = STRIP_RESET;
    logic [LIMIT_W-1:0] cfg_limit     = LIMIT_RESET;
    scan_phase_t        scan_phase    = SCAN_TEXT;
    logic [7:0]         held_seq [SEQ_LIMIT];
    int                 held_len      = 0;
    logic [COUNT_W-1:0] byte_total    = '0;
    bit                 chunk_open    = 1'b0;
    bit                 chunk_blocked = 1'b0;
    acsc_out_t          capture_q[$];

    // Stimulus and bookkeeping.
    acsc_in_t send_q[$];
    int       send_mode     = 1;
    int       recv_mode     = 1;
    int       send_gap      = 0;
    int       recv_gap      = 0;
    bit       word_taken    = 1'b0;
    int       hold_off_req  = 0;
    int       hold_off_left = 0;
    int       words_sent    = 0;
    int       chunks_sent   = 0;
    int       csi_sent      = 0;
    int       results_seen  = 0;
    int       error_count   = 0;
    int       cycle_count   = 0;

    // Per-phase settings of the random part.
    int ph_cap   [NUM_PHASES] = '{1, 1, 1, 0, 1, 1};
    int ph_strip [NUM_PHASES] = '{1, 0, 1, 1, 1, 0};
    int ph_limit [NUM_PHASES] = '{0, 4095, 1, 100, 2048, 0};
    int ph_items [NUM_PHASES] = '{70, 50, 60, 15, 90, 60};
    int ph_send  [NUM_PHASES] = '{0, 1, 0, 1, 2, 2};
    int ph_recv  [NUM_PHASES] = '{0, 1, 0, 1, 2, 0};

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic bit is_final_char(input logic [7:0] c);
        return (c >= CH_UPPER_LO && c <= CH_UPPER_HI) || (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
    endfunction

    function automatic bit is_param_char(input logic [7:0] c);
        return (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) || c == CH_SEMI || c == CH_QUEST ||
               c == CH_EQUAL;
    endfunction

    task automatic push_result(input logic kind, input logic [7:0] b, input logic refused);
        acsc_out_t r;
        r.kind        = kind;
        r.out_byte    = b;
        r.refused     = refused;
        r.last_of_run = 1'b0;
        capture_q.push_back(r);
    endtask

    // A captured byte bumps the saturating byte total.
    task automatic emit_captured(input logic [7:0] b);
        push_result(KIND_BYTE, b, 1'b0);
        if (byte_total != '1) begin
            byte_total = byte_total + 1'b1;
        end
    endtask

    task automatic release_held();
        for (int i = 0; i < held_len; i++) begin
            emit_captured(held_seq[i]);
        end
        held_len   = 0;
        scan_phase = SCAN_TEXT;
    endtask

    task automatic hold_byte(input logic [7:0] c);
        if (held_len < SEQ_LIMIT) begin
            held_seq[held_len] = c;
            held_len++;
        end
    endtask

    // One byte through the escape parser; a breaking byte falls back to plain text.
    task automatic scan_byte(input logic [7:0] c);
        bit as_text;
        as_text = 1'b1;
        case (scan_phase)
            SCAN_ESC: begin
                if (c == CH_LBRACKET) begin
                    hold_byte(c);
                    scan_phase = SCAN_CSI;
                    as_text    = 1'b0;
                end else begin
                    release_held();
                end
            end
            SCAN_CSI: begin
                if (is_final_char(c)) begin
                    held_len   = 0;
                    scan_phase = SCAN_TEXT;
                    as_text    = 1'b0;
                end else if (is_param_char(c)) begin
                    if (held_len < SEQ_LIMIT - 1) begin
                        hold_byte(c);
                    end else begin
                        // The store is full: the sequence goes out as literals.
                        release_held();
                        emit_captured(c);
                    end
                    as_text = 1'b0;
                end else begin
                    release_held();
                end
            end
            default: ;
        endcase
        if (as_text) begin
            scan_phase = SCAN_TEXT;
            if (c == CH_ESC) begin
                held_len = 0;
                hold_byte(c);
                scan_phase = SCAN_ESC;
            end else begin
                emit_captured(c);
            end
        end
    endtask

    // Works out every result that one accepted input word causes.
    task automatic capture_word(input acsc_in_t w);
        int                 base;
        logic [COUNT_W-1:0] limit_bytes;
        bit                 over;
        base        = capture_q.size();
        limit_bytes = COUNT_W'(cfg_limit) << MIB_SHIFT;
        if (!chunk_open) begin
            // Refusal is decided once, on the first word of a chunk.
            over          = (cfg_limit != 0) && (byte_total > limit_bytes);
            chunk_blocked = !cfg_capture || over;
            chunk_open    = 1'b1;
            held_len      = 0;
            scan_phase    = SCAN_TEXT;
        end
        if (!chunk_blocked) begin
            if (cfg_strip) begin
                scan_byte(w.data_byte);
            end else begin
                if (scan_phase != SCAN_TEXT || held_len != 0) begin
                    release_held();
                end
                emit_captured(w.data_byte);
            end
        end
        if (w.chunk_end) begin
            release_held();
            push_result(KIND_STATUS, 8'h00, chunk_blocked);
            chunk_open    = 1'b0;
            chunk_blocked = 1'b0;
        end
        if (capture_q.size() > base) begin
            capture_q[capture_q.size() - 1].last_of_run = 1'b1;
        end
    endtask

    task automatic apply_reg(input logic [1:0] idx, input logic [LIMIT_W-1:0] val);
        case (idx)
            REG_CAPTURE_ON: begin
                cfg_capture = val[0];
                if (val[0]) begin
                    byte_total = '0;
                end
            end
            REG_STRIP_ENABLE: begin
                cfg_strip = val[0];
            end
            REG_LIMIT_MIB: begin
                cfg_limit = val;
            end
            default: ;
        endcase
    endtask

    // Register write followed by a read-back of the same address.
    task automatic set_reg(input logic [1:0] idx, input logic [LIMIT_W-1:0] val);
        logic [DATA_W-1:0] wval;
        wval = (idx == REG_LIMIT_MIB) ? DATA_W'(val) : DATA_W'(val[0]);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wval;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        apply_reg(idx, val);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== wval) begin
            flag_error($sformatf("register %0d read back %0h, wrote %0h", idx, prdata, wval));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_word(input logic [7:0] b, input bit last);
        acsc_in_t w;
        w.data_byte = b;
        w.chunk_end = last;
        send_q.push_back(w);
        words_sent++;
    endtask

    function automatic logic [7:0] rand_param();
        int r;
        r = $urandom_range(0, 12);
        if (r <= 9) begin
            return CH_DIGIT_LO + 8'(r);
        end else if (r == 10) begin
            return CH_SEMI;
        end else if (r == 11) begin
            return CH_QUEST;
        end
        return CH_EQUAL;
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0) begin
            return CH_UPPER_LO + 8'($urandom_range(0, 25));
        end
        return CH_LOWER_LO + 8'($urandom_range(0, 25));
    endfunction

    function automatic int draw_gap(input int mode);
        case (mode)
            0: return 0;
            1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    // A chunk built from a random mix of well-formed sequences, broken ones and plain bytes.
    task automatic add_random_chunk();
        int segs;
        int pick;
        int n;
        bit cut;
        segs = $urandom_range(1, 4);
        cut  = 1'b0;
        for (int s = 0; s < segs && !cut; s++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                // Now and then long enough to overflow the held-byte store.
                n = ($urandom_range(0, 6) == 0) ? $urandom_range(12, 16) : $urandom_range(0, 4);
                add_word(CH_ESC, 1'b0);
                add_word(CH_LBRACKET, 1'b0);
                repeat (n) add_word(rand_param(), 1'b0);
                add_word(rand_letter(), 1'b0);
                csi_sent++;
            end else if (pick == 4) begin
                add_word(CH_ESC, 1'b0);
                add_word(CH_LBRACKET, 1'b0);
                repeat ($urandom_range(0, 3)) add_word(rand_param(), 1'b0);
                add_word(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick == 5) begin
                add_word(CH_ESC, 1'b0);
                add_word(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick == 6) begin
                // Sequence left open when the chunk ends.
                add_word(CH_ESC, 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    add_word(CH_LBRACKET, 1'b0);
                    repeat ($urandom_range(0, 5)) add_word(rand_param(), 1'b0);
                end
                cut = 1'b1;
            end else begin
                repeat ($urandom_range(1, 4)) add_word(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        send_q[send_q.size() - 1].chunk_end = 1'b1;
        chunks_sent++;
    endtask

    // Waits until every word is taken and every result has come back.
    task automatic wait_idle();
        while (send_q.size() != 0 || s_valid || capture_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Input driver: presents one word at a time and waits a drawn gap after each.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || word_taken) begin
                word_taken = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (send_q.size() > 0) begin
                    s_data   <= send_q.pop_front();
                    s_valid  <= 1'b1;
                    send_gap = draw_gap(send_mode);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: drawn stalls per word, plus the occasional long hold-off.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_off_req > 0) begin
                hold_off_left = hold_off_req;
                hold_off_req  = 0;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: runs the model on accepted input words and checks every result word.
    always @(posedge aclk) begin
        acsc_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                word_taken = 1'b1;
                capture_word(s_data);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                recv_gap = draw_gap(recv_mode);
                if (capture_q.size() == 0) begin
                    flag_error($sformatf("unexpected result %h", m_data));
                end else begin
                    want = capture_q.pop_front();
                    if (m_data.kind !== want.kind) begin
                        flag_error($sformatf("result %0d kind %b, want %b",
                                             results_seen, m_data.kind, want.kind));
                    end
                    if (m_data.out_byte !== want.out_byte) begin
                        flag_error($sformatf("result %0d byte %h, want %h",
                                             results_seen, m_data.out_byte, want.out_byte));
                    end
                    if (m_data.refused !== want.refused) begin
                        flag_error($sformatf("result %0d refused %b, want %b",
                                             results_seen, m_data.refused, want.refused));
                    end
                    if (m_data.last_of_run !== want.last_of_run) begin
                        flag_error($sformatf("result %0d last %b, want %b",
                                             results_seen, m_data.last_of_run,
                                             want.last_of_run));
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycle_count, capture_q.size());
            $display("FAIL ansi_csi_strip_capture");
            $finish;
        end
    end

    initial begin
        int start;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Capture is off after reset, so the first chunk is refused.
        add_word(8'h41, 1'b0);
        add_word(8'hFF, 1'b1);
        wait_idle();
        set_reg(REG_CAPTURE_ON, 12'd1);

        // Removed sequence with every parameter class, a broken escape, a sequence
        // broken inside its parameters, and one cut off by the chunk end.
        add_word(8'h00, 1'b0);
        add_word(CH_ESC, 1'b0);
        add_word(CH_LBRACKET, 1'b0);
        add_word(CH_DIGIT_LO, 1'b0);
        add_word(CH_SEMI, 1'b0);
        add_word(CH_QUEST, 1'b0);
        add_word(CH_EQUAL, 1'b0);
        add_word(CH_DIGIT_HI, 1'b0);
        add_word(CH_LOWER_HI, 1'b0);
        add_word(CH_ESC, 1'b0);
        add_word(8'h71, 1'b0);
        add_word(CH_ESC, 1'b0);
        add_word(CH_LBRACKET, 1'b0);
        add_word(8'h21, 1'b0);
        add_word(CH_ESC, 1'b0);
        add_word(CH_LBRACKET, 1'b0);
        add_word(8'h37, 1'b1);
        wait_idle();

        // Stripping turned off while a sequence is held in an open chunk.
        add_word(CH_ESC, 1'b0);
        add_word(CH_LBRACKET, 1'b0);
        add_word(8'h34, 1'b0);
        wait_idle();
        set_reg(REG_STRIP_ENABLE, 12'd0);
        add_word(8'h80, 1'b1);
        wait_idle();
        chunks_sent += 3;

        // Random phases, each under its own register setting and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_reg(REG_CAPTURE_ON, 12'(ph_cap[p]));
            set_reg(REG_STRIP_ENABLE, 12'(ph_strip[p]));
            set_reg(REG_LIMIT_MIB, 12'(ph_limit[p]));
            send_mode = ph_send[p];
            recv_mode = ph_recv[p];
            start     = words_sent;
            while (words_sent - start < ph_items[p]) begin
                add_random_chunk();
            end
            if (p == 2) begin
                // Long output stall while input keeps coming, to back the block up.
                hold_off_req = LONG_HOLD_OFF;
            end
            wait_idle();
        end

        $display("Sent %0d words in %0d chunks (%0d well-formed CSI sequences), checked %0d results",
                 words_sent, chunks_sent, csi_sent, results_seen);
        $display("Settings: capture on and off, stripping on and off, limits 0 to 4095 MiB");
        if (error_count == 0) begin
            $display("PASS ansi_csi_strip_capture");
        end else begin
            $display("FAIL ansi_csi_strip_capture");
        end
        $finish;
    end

endmodule

// ===== ansi_csi_strip_capture.f =====
design/acsc_pkg.sv
design/acsc_front.sv
design/acsc_queue.sv
design/acsc_back.sv
design/ansi_csi_strip_capture.sv
design/acsc_checker.sv
dv/tb_ansi_csi_strip_capture.sv
